### design/abb_pkg.sv
// Shared types and codes of the alpha-blend blitter.
package abb_pkg;

    // Command carried in the input transaction's tuser.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_BLIT  = 2'd2
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_DEST_X        = 3'd0,
        REG_DEST_Y        = 3'd1,
        REG_REGION_WIDTH  = 3'd2,
        REG_REGION_HEIGHT = 3'd3,
        REG_BLEND_ON      = 3'd4,
        REG_ALPHA         = 3'd5
    } reg_index_t;

    localparam logic [7:0]  FULL_WEIGHT  = 8'd255;
    localparam int unsigned WEIGHT_SHIFT = 8;

    // Placement of the current blit byte as seen by the cursor.
    typedef struct packed {
        logic clip;
        logic last;
    } place_t;

endpackage

### design/abb_cursor.sv
// Raster cursor of the blit: column, row and channel counters and target address.
module abb_cursor #(
    parameter int unsigned DEST_WIDTH      = 64,
    parameter int unsigned DEST_HEIGHT     = 64,
    parameter int unsigned BYTES_PER_PIXEL = 4,
    parameter int unsigned ADDR_W          = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [5:0]        dest_x,
    input  logic [5:0]        dest_y,
    input  logic [6:0]        region_width,
    input  logic [6:0]        region_height,
    output logic [ADDR_W-1:0] pos,
    output abb_pkg::place_t   place
);

    logic [6:0] col_reg, col_next;
    logic [6:0] row_reg, row_next;
    logic [1:0] chan_reg, chan_next;
    logic [6:0] col_inc, row_inc;
    logic [1:0] chan_inc;
    logic       chan_wrap, col_wrap, row_wrap;
    logic [7:0] tgt_col, tgt_row;
    logic [31:0] pos_full;

    always_comb begin
        tgt_col  = {2'b00, dest_x} + {1'b0, col_reg};
        tgt_row  = {2'b00, dest_y} + {1'b0, row_reg};
        pos_full = (32'(tgt_row) * DEST_WIDTH + 32'(tgt_col)) * BYTES_PER_PIXEL
                   + 32'(chan_reg);
        pos      = pos_full[ADDR_W-1:0];

        place.clip = (32'(tgt_col) >= DEST_WIDTH) || (32'(tgt_row) >= DEST_HEIGHT) ||
                     (32'(chan_reg) >= BYTES_PER_PIXEL);

        // A bound of zero behaves as one because a counter that wraps to zero ends its run.
        chan_inc  = chan_reg + 2'd1;
        col_inc   = col_reg + 7'd1;
        row_inc   = row_reg + 7'd1;
        chan_wrap = (32'(chan_inc) >= BYTES_PER_PIXEL) || (chan_inc == 2'd0);
        col_wrap  = (col_inc >= region_width) || (col_inc == 7'd0);
        row_wrap  = (row_inc >= region_height) || (row_inc == 7'd0);
        place.last = chan_wrap && col_wrap && row_wrap;

        chan_next = chan_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (step) begin
            chan_next = chan_wrap ? 2'd0 : chan_inc;
            if (chan_wrap) begin
                col_next = col_wrap ? 7'd0 : col_inc;
                if (col_wrap) begin
                    row_next = row_wrap ? 7'd0 : row_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= 7'd0;
            row_reg  <= 7'd0;
            chan_reg <= 2'd0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            chan_reg <= chan_next;
        end
    end

endmodule

### design/alpha_blend_blitter.sv
// Each accepted input passes the blend-stage and output registers. Throughput: one
// item per cycle unless results stall; the store's single registered read port
// is read as an item enters and written back as it leaves the blend stage.
// Reset (synchronous, active low) clears the handshake state, the cursor and the
// configuration registers; the destination store is not cleared and holds
// undefined bytes until written.
module alpha_blend_blitter #(
    parameter int unsigned DEST_WIDTH      = 64,
    parameter int unsigned DEST_HEIGHT     = 64,
    parameter int unsigned BYTES_PER_PIXEL = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [13:0] address, [21:14] data, [23:22] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] read_data
    output logic        m_axis_tlast,  // region_last
    output logic        m_axis_tuser,  // [0] clipped
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int unsigned STORE_BYTES = DEST_WIDTH * DEST_HEIGHT * BYTES_PER_PIXEL;
    localparam int unsigned ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    // Configuration registers.
    logic [5:0] dest_x_reg, dest_y_reg;
    logic [6:0] region_width_reg, region_height_reg;
    logic       blend_on_reg;
    logic [7:0] alpha_reg;

    // Input decode.
    abb_pkg::cmd_t in_cmd;
    logic [13:0]   in_address;
    logic [7:0]    in_data;
    logic          s_accept;

    // Cursor.
    logic [ADDR_W-1:0] blit_pos;
    abb_pkg::place_t   place;

    // Blend stage.
    logic              s1_valid_reg;
    abb_pkg::cmd_t     s1_cmd_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_data_reg;
    logic              s1_ok_reg;
    logic              s1_last_reg;
    logic              s1_clip_reg;
    logic              s1_fire;

    logic [7:0]        store_mem [STORE_BYTES];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              in_ok;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [7:0]        fwd_data_reg;

    logic [7:0]  dst;
    logic [15:0] blend_sum;
    logic [7:0]  blit_val;
    logic        wr_en;
    logic [7:0]  wr_data;
    logic [7:0]  out_data;

    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        m_last_reg;
    logic        m_clip_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_x_reg        <= 6'd0;
            dest_y_reg        <= 6'd0;
            region_width_reg  <= 7'd64;
            region_height_reg <= 7'd64;
            blend_on_reg      <= 1'b0;
            alpha_reg         <= 8'd255;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                abb_pkg::REG_DEST_X:        dest_x_reg        <= cfg_data[5:0];
                abb_pkg::REG_DEST_Y:        dest_y_reg        <= cfg_data[5:0];
                abb_pkg::REG_REGION_WIDTH:  region_width_reg  <= cfg_data[6:0];
                abb_pkg::REG_REGION_HEIGHT: region_height_reg <= cfg_data[6:0];
                abb_pkg::REG_BLEND_ON:      blend_on_reg      <= cfg_data[0];
                abb_pkg::REG_ALPHA:         alpha_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_cmd     = abb_pkg::cmd_t'(s_axis_tuser);
    assign in_address = s_axis_tdata[13:0];
    assign in_data    = s_axis_tdata[21:14];

    assign s1_fire       = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    abb_cursor #(
        .DEST_WIDTH      (DEST_WIDTH),
        .DEST_HEIGHT     (DEST_HEIGHT),
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
        .ADDR_W          (ADDR_W)
    ) u_cursor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (s_accept && (in_cmd == abb_pkg::CMD_BLIT)),
        .dest_x        (dest_x_reg),
        .dest_y        (dest_y_reg),
        .region_width  (region_width_reg),
        .region_height (region_height_reg),
        .pos           (blit_pos),
        .place         (place)
    );

    always_comb begin
        if (in_cmd == abb_pkg::CMD_BLIT) begin
            rd_addr = blit_pos;
            in_ok   = !place.clip;
        end else begin
            rd_addr = ADDR_W'(in_address);
            in_ok   = 32'(in_address) < STORE_BYTES;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg  <= in_cmd;
            s1_addr_reg <= rd_addr;
            s1_data_reg <= in_data;
            s1_ok_reg   <= in_ok;
            s1_last_reg <= (in_cmd == abb_pkg::CMD_BLIT) && place.last;
            s1_clip_reg <= (in_cmd == abb_pkg::CMD_BLIT) && place.clip;
        end
    end

    // The store returns the old byte when it is written at the edge it is read, so
    // the write of the item ahead is kept and forwarded to the item that entered then.
    always_ff @(posedge aclk) begin
        if (s1_fire && wr_en) begin
            store_mem[s1_addr_reg] <= wr_data;
        end
        if (s_accept) begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_valid_reg <= s1_fire && wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= wr_data;
        end
    end

    always_comb begin
        dst = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rdata_reg;
        blend_sum = 16'(s1_data_reg) * 16'(alpha_reg)
                  + 16'(dst) * 16'(abb_pkg::FULL_WEIGHT - alpha_reg);
        blit_val  = blend_on_reg ? blend_sum[abb_pkg::WEIGHT_SHIFT +: 8] : s1_data_reg;

        wr_en    = 1'b0;
        wr_data  = s1_data_reg;
        out_data = 8'd0;
        unique case (s1_cmd_reg)
            abb_pkg::CMD_WRITE: begin
                wr_en = s1_ok_reg;
            end
            abb_pkg::CMD_READ: begin
                out_data = s1_ok_reg ? dst : 8'd0;
            end
            abb_pkg::CMD_BLIT: begin
                wr_en    = s1_ok_reg;
                wr_data  = blit_val;
                out_data = s1_ok_reg ? blit_val : 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg <= out_data;
            m_last_reg <= s1_last_reg;
            m_clip_reg <= s1_clip_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_clip_reg;

endmodule

### design/abb_checker.sv
// Port-level checks of the alpha-blend blitter and their binding to it.
module abb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser
);

    logic [2:0] pending_reg;
    logic       s_acc, m_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // Transactions accepted but not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
        end else begin
            pending_reg <= pending_reg + 3'(s_acc) - 3'(m_acc);
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("result offered with no transaction outstanding");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd2)
        else $error("more transactions in flight than the pipeline holds");

    a_clip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
        else $error("dropped byte reported with non-zero data");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind alpha_blend_blitter abb_checker u_abb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### test/alpha_blend_blitter_tb.sv
// Self-checking testbench for the alpha-blend blitter: host accesses, blits and register phases.
module alpha_blend_blitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEST_W       = 64;
    localparam int unsigned DEST_H       = 64;
    localparam int unsigned BPP          = 4;
    localparam int unsigned STORE_BYTES  = DEST_W * DEST_H * BPP;
    localparam int unsigned PIPE_LATENCY = 2;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned REPORT_LINES = 40;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    typedef struct packed {
        logic [7:0] rd;
        logic       last;
        logic       clip;
    } blit_out_t;

    // Mirrors the destination store, the raster cursor and the registers.
    class blit_scoreboard;
        logic [7:0] dest_bytes [STORE_BYTES];
        bit         loaded [STORE_BYTES];
        logic [6:0] cur_col;
        logic [6:0] cur_row;
        logic [1:0] cur_chan;
        logic [5:0] org_x;
        logic [5:0] org_y;
        logic [6:0] rect_w;
        logic [6:0] rect_h;
        logic       blend_en;
        logic [7:0] weight;
        blit_out_t  expected_q [$];
        int         errors;
        int         n_in;
        int         n_checked;
        int         n_blit;
        int         n_clip;
        int         n_last;

        function new();
            cur_col  = '0;
            cur_row  = '0;
            cur_chan = '0;
            org_x    = '0;
            org_y    = '0;
            rect_w   = 7'd64;
            rect_h   = 7'd64;
            blend_en = 1'b0;
            weight   = 8'd255;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        function void set_reg(abb_pkg::reg_index_t idx, logic [7:0] value);
            case (idx)
                abb_pkg::REG_DEST_X:        org_x    = value[5:0];
                abb_pkg::REG_DEST_Y:        org_y    = value[5:0];
                abb_pkg::REG_REGION_WIDTH:  rect_w   = value[6:0];
                abb_pkg::REG_REGION_HEIGHT: rect_h   = value[6:0];
                abb_pkg::REG_BLEND_ON:      blend_en = value[0];
                abb_pkg::REG_ALPHA:         weight   = value;
                default: ;
            endcase
        endfunction

        // Store byte that the next blit transaction lands on; 0 when it falls outside.
        function bit next_target(output int unsigned pos);
            int unsigned col;
            int unsigned row;
            col = 32'(org_x) + 32'(cur_col);
            row = 32'(org_y) + 32'(cur_row);
            pos = (row * DEST_W + col) * BPP + 32'(cur_chan);
            return (col < DEST_W) && (row < DEST_H) && (32'(cur_chan) < BPP);
        endfunction

        // A counter at or beyond a freshly lowered bound wraps here as well.
        function bit step_cursor();
            cur_chan = cur_chan + 2'd1;
            if (32'(cur_chan) < BPP && cur_chan != 2'd0) return 1'b0;
            cur_chan = '0;
            cur_col  = cur_col + 7'd1;
            if (cur_col < rect_w && cur_col != 7'd0) return 1'b0;
            cur_col = '0;
            cur_row = cur_row + 7'd1;
            if (cur_row < rect_h && cur_row != 7'd0) return 1'b0;
            cur_row = '0;
            return 1'b1;
        endfunction

        function void note_input(logic [1:0] cmd, logic [13:0] addr, logic [7:0] data);
            blit_out_t   res;
            int unsigned pos;
            int unsigned mix;
            int unsigned src;
            int unsigned dst;
            int unsigned w;
            res = '0;
            n_in++;
            case (cmd)
                abb_pkg::CMD_WRITE: begin
                    dest_bytes[addr] = data;
                    loaded[addr]     = 1'b1;
                end
                abb_pkg::CMD_READ: res.rd = dest_bytes[addr];
                abb_pkg::CMD_BLIT: begin
                    n_blit++;
                    if (next_target(pos)) begin
                        src = 32'(data);
                        dst = 32'(dest_bytes[pos]);
                        w   = 32'(weight);
                        mix = blend_en ? ((src * w + dst * (32'(abb_pkg::FULL_WEIGHT) - w))
                                          >> abb_pkg::WEIGHT_SHIFT)
                                       : src;
                        dest_bytes[pos] = mix[7:0];
                        loaded[pos]     = 1'b1;
                        res.rd          = mix[7:0];
                    end else begin
                        res.clip = 1'b1;
                        n_clip++;
                    end
                    res.last = step_cursor();
                    if (res.last) n_last++;
                end
                default: ;
            endcase
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_LINES) $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        task check_result(logic [7:0] rd, logic last, logic clip);
            blit_out_t exp;
            n_checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding (data %02h)",
                                 n_checked, rd));
                return;
            end
            exp = expected_q.pop_front();
            if (rd !== exp.rd)
                report($sformatf("result %0d read_data %02h, expected %02h",
                                 n_checked, rd, exp.rd));
            if (last !== exp.last)
                report($sformatf("result %0d region_last %b, expected %b",
                                 n_checked, last, exp.last));
            if (clip !== exp.clip)
                report($sformatf("result %0d clipped %b, expected %b",
                                 n_checked, clip, exp.clip));
        endtask
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = '0;
    logic [7:0]  cfg_data      = '0;

    blit_scoreboard sb = new();

    int unsigned cycles     = 0;
    int          burst_left = 0;
    int          sent_count = 0;
    int          phases     = 0;
    int unsigned last_blit_pos = 0;

    alpha_blend_blitter #(
        .DEST_WIDTH     (DEST_W),
        .DEST_HEIGHT    (DEST_H),
        .BYTES_PER_PIXEL(BPP)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.expected_q.size());
            $display("alpha_blend_blitter_tb: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // Receiver: segments of steady acceptance, random acceptance and long stalls.
    int rx_mode  = 0;
    int seg_left = 0;
    int stall    = 0;
    always @(posedge aclk) begin
        if (seg_left == 0) begin
            rx_mode  = $urandom_range(0, 2);
            seg_left = $urandom_range(20, 200);
        end else begin
            seg_left = seg_left - 1;
        end
        if (rx_mode == 0) begin
            m_axis_tready <= 1'b1;
        end else if (rx_mode == 1) begin
            m_axis_tready <= ($urandom_range(0, 9) < 7);
        end else if (stall > 0) begin
            stall = stall - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall = $urandom_range(3, 20);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [13:0] addr,
                             input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, data, addr};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_input(cmd, addr, data);
        burst_left--;
        sent_count++;
    endtask

    // A blend may only read back a byte that has been loaded, so load it first if needed.
    task automatic do_blit(input logic [7:0] data);
        int unsigned pos;
        bit          inside_dest;
        inside_dest = sb.next_target(pos);
        if (inside_dest) begin
            last_blit_pos = pos;
            if (sb.blend_en && !sb.loaded[pos])
                send_item(abb_pkg::CMD_WRITE, pos[13:0], 8'($urandom_range(0, 255)));
        end
        send_item(abb_pkg::CMD_BLIT, 14'($urandom_range(0, STORE_BYTES - 1)), data);
    endtask

    task automatic do_read(input logic [13:0] addr);
        if (!sb.loaded[addr])
            send_item(abb_pkg::CMD_WRITE, addr, 8'($urandom_range(0, 255)));
        send_item(abb_pkg::CMD_READ, addr, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input abb_pkg::reg_index_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        sb.set_reg(idx, value);
    endtask

    task automatic configure(input logic [7:0] dx, input logic [7:0] dy, input logic [7:0] w,
                             input logic [7:0] h, input logic [7:0] blend,
                             input logic [7:0] alpha_val);
        drain();
        write_reg(abb_pkg::REG_DEST_X, dx);
        write_reg(abb_pkg::REG_DEST_Y, dy);
        write_reg(abb_pkg::REG_REGION_WIDTH, w);
        write_reg(abb_pkg::REG_REGION_HEIGHT, h);
        write_reg(abb_pkg::REG_BLEND_ON, blend);
        write_reg(abb_pkg::REG_ALPHA, alpha_val);
        cfg_valid <= 1'b0;
    endtask

    // Upper bits are random so that register masking is exercised too.
    function automatic logic [7:0] pick_origin();
        int r;
        logic [7:0] v;
        r = $urandom_range(0, 99);
        v = (r < 25) ? 8'd0 : (r < 50) ? 8'd63 : 8'($urandom_range(0, 63));
        v[7:6] = 2'($urandom_range(0, 3));
        return v;
    endfunction

    function automatic logic [7:0] pick_size();
        int r;
        logic [7:0] v;
        r = $urandom_range(0, 99);
        if (r < 55)      v = 8'($urandom_range(1, 4));
        else if (r < 65) v = 8'd0;
        else if (r < 75) v = 8'd64;
        else if (r < 85) v = 8'($urandom_range(65, 127));
        else             v = 8'($urandom_range(5, 16));
        v[7] = 1'($urandom_range(0, 1));
        return v;
    endfunction

    function automatic logic [7:0] pick_alpha();
        int r;
        r = $urandom_range(0, 9);
        return (r < 2) ? 8'd0 : (r < 4) ? 8'd255 : 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int start;
        int n;
        int r;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Host accesses at the address extremes, the unused command and a copy blit.
        send_item(abb_pkg::CMD_WRITE, 14'h0000, 8'h00);
        send_item(abb_pkg::CMD_WRITE, 14'h3FFF, 8'hFF);
        send_item(abb_pkg::CMD_WRITE, 14'h2AAA, 8'h5A);
        do_read(14'h3FFF);
        do_read(14'h0000);
        do_read(14'h2AAA);
        send_item(CMD_UNUSED, 14'h3FFF, 8'hFF);
        do_blit(8'hFF);
        do_blit(8'h00);
        do_blit(8'hA5);
        do_blit(8'h5A);
        do_read(14'h0002);

        // Tiny rectangle at the far corner, changed mid-blit: every byte is clipped.
        configure(8'hFF, 8'hFF, 8'h82, 8'h02, 8'h01, 8'h00);
        repeat (12) do_blit(8'($urandom_range(0, 255)));

        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS) begin
            configure(pick_origin(), pick_origin(), pick_size(), pick_size(),
                      8'($urandom_range(0, 255)), pick_alpha());
            phases++;
            n = $urandom_range(30, 90);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    do_blit(8'($urandom_range(0, 255)));
                else if (r < 80)
                    send_item(abb_pkg::CMD_WRITE, 14'($urandom_range(0, STORE_BYTES - 1)),
                              8'($urandom_range(0, 255)));
                else if (r < 93)
                    do_read($urandom_range(0, 1) ? last_blit_pos[13:0]
                                                 : 14'($urandom_range(0, STORE_BYTES - 1)));
                else
                    send_item(CMD_UNUSED, 14'($urandom_range(0, STORE_BYTES - 1)),
                              8'($urandom_range(0, 255)));
            end
        end

        drain();
        $display("%0d transactions in, %0d results checked over %0d register phases",
                 sb.n_in, sb.n_checked, phases + 1);
        $display("%0d blit bytes, %0d clipped, %0d rectangles completed",
                 sb.n_blit, sb.n_clip, sb.n_last);
        if (sb.errors == 0) begin
            $display("alpha_blend_blitter_tb: PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("alpha_blend_blitter_tb: FAIL");
        end
        $finish;
    end

endmodule
